/* hdl/spmv_pkg.sv */
package spmv_pkg;

  localparam int KIND_W = 2;
  localparam int IDX_W  = 10;
  localparam int VAL_W  = 32;
  localparam int RES_W  = 64;

  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD = 2'd0,
    KIND_ACC  = 2'd1,
    KIND_READ = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_MUL,
    ST_ACC,
    ST_RET
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;
    logic clear_wr;
    logic vec_wr;
    logic acc_wr;
    logic ret;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    kind_t kind;
    logic  row_ok;
    logic  col_ok;
    logic  out_free;
    logic  clear_last;
  } status_t;

endpackage

/* hdl/spmv_if.sv */
interface spmv_in_if;
  logic                        valid;
  logic                        ready;
  logic [spmv_pkg::KIND_W-1:0] kind;
  logic [spmv_pkg::IDX_W-1:0]  row_index;
  logic [spmv_pkg::IDX_W-1:0]  col_index;
  logic signed [spmv_pkg::VAL_W-1:0] value;

  modport source (output valid, kind, row_index, col_index, value, input ready);
  modport sink (input valid, kind, row_index, col_index, value, output ready);
endinterface

interface spmv_out_if;
  logic                              valid;
  logic                              ready;
  logic [spmv_pkg::IDX_W-1:0]        result_index;
  logic signed [spmv_pkg::RES_W-1:0] result_value;

  modport source (output valid, result_index, result_value, input ready);
  modport sink (input valid, result_index, result_value, output ready);
endinterface

/* hdl/spmv_ctrl.sv */
module spmv_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  spmv_pkg::status_t  sts,
  output spmv_pkg::cmd_t     cmd
);

  spmv_pkg::state_t state;
  spmv_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= spmv_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      spmv_pkg::ST_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (sts.clear_last) begin
          state_next = spmv_pkg::ST_IDLE;
        end
      end
      spmv_pkg::ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
        if (in_valid) begin
          state_next = spmv_pkg::ST_READ;
        end
      end
      spmv_pkg::ST_READ: begin
        // memory reads at the captured addresses are in flight
        unique case (sts.kind)
          spmv_pkg::KIND_LOAD: begin
            cmd.vec_wr = sts.col_ok;
            state_next = spmv_pkg::ST_IDLE;
          end
          spmv_pkg::KIND_ACC: begin
            state_next = (sts.row_ok && sts.col_ok) ? spmv_pkg::ST_MUL : spmv_pkg::ST_IDLE;
          end
          spmv_pkg::KIND_READ: begin
            state_next = spmv_pkg::ST_RET;
          end
          default: begin
            state_next = spmv_pkg::ST_IDLE;
          end
        endcase
      end
      spmv_pkg::ST_MUL: begin
        state_next = spmv_pkg::ST_ACC;
      end
      spmv_pkg::ST_ACC: begin
        cmd.acc_wr = 1'b1;
        state_next = spmv_pkg::ST_IDLE;
      end
      spmv_pkg::ST_RET: begin
        // hold until the output register can take the result
        if (sts.out_free) begin
          cmd.ret    = 1'b1;
          state_next = spmv_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = spmv_pkg::ST_IDLE;
      end
    endcase
  end

  a_one_result_writer: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.clear_wr, cmd.acc_wr, cmd.ret}))
    else $error("more than one writer on the result store port");

  a_ret_needs_room: assert property (@(posedge clk) disable iff (rst)
    cmd.ret |-> sts.out_free)
    else $error("result loaded over a pending output transfer");

  a_capture_then_read: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |=> state == spmv_pkg::ST_READ)
    else $error("captured item did not advance to the read step");

endmodule

/* hdl/spmv_dpath.sv */
module spmv_dpath #(
  parameter int MAX_DIM = 1024
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic [spmv_pkg::KIND_W-1:0]        kind,
  input  logic [spmv_pkg::IDX_W-1:0]         row_index,
  input  logic [spmv_pkg::IDX_W-1:0]         col_index,
  input  logic signed [spmv_pkg::VAL_W-1:0]  value,
  input  spmv_pkg::cmd_t                     cmd,
  output spmv_pkg::status_t                  sts,
  spmv_out_if.source                         results
);

  localparam int AW = $clog2(MAX_DIM);
  localparam int IW = (AW > spmv_pkg::IDX_W) ? AW : spmv_pkg::IDX_W;
  localparam logic [IW:0]   DIM  = (IW + 1)'(MAX_DIM);
  localparam logic [AW-1:0] LAST = AW'(MAX_DIM - 1);

  localparam logic signed [spmv_pkg::RES_W-1:0] SAT_MAX = {1'b0, {(spmv_pkg::RES_W-1){1'b1}}};
  localparam logic signed [spmv_pkg::RES_W-1:0] SAT_MIN = {1'b1, {(spmv_pkg::RES_W-1){1'b0}}};

  logic [spmv_pkg::KIND_W-1:0]        item_kind;
  logic [spmv_pkg::IDX_W-1:0]         item_row;
  logic [spmv_pkg::IDX_W-1:0]         item_col;
  logic signed [spmv_pkg::VAL_W-1:0]  item_value;

  logic [IW-1:0] row_ext;
  logic [IW-1:0] col_ext;
  logic [AW-1:0] row_addr;
  logic [AW-1:0] col_addr;
  logic          row_ok;
  logic          col_ok;

  logic [spmv_pkg::VAL_W-1:0] vec_mem [MAX_DIM];
  logic [spmv_pkg::RES_W-1:0] res_mem [MAX_DIM];

  logic signed [spmv_pkg::VAL_W-1:0] vec_rd;
  logic signed [spmv_pkg::RES_W-1:0] res_rd;
  logic signed [spmv_pkg::RES_W-1:0] prod;
  logic signed [spmv_pkg::RES_W:0]   sum;
  logic signed [spmv_pkg::RES_W-1:0] sum_sat;

  logic [AW-1:0]              clr_cnt;
  logic                       res_we;
  logic [AW-1:0]              res_waddr;
  logic [spmv_pkg::RES_W-1:0] res_wdata;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_kind  <= kind;
      item_row   <= row_index;
      item_col   <= col_index;
      item_value <= value;
    end
  end

  assign row_ext  = IW'(item_row);
  assign col_ext  = IW'(item_col);
  assign row_ok   = {1'b0, row_ext} < DIM;
  assign col_ok   = {1'b0, col_ext} < DIM;
  assign row_addr = row_ext[AW-1:0];
  assign col_addr = col_ext[AW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.vec_wr) begin
      vec_mem[col_addr] <= item_value;
    end
    vec_rd <= vec_mem[col_addr];
  end

  // Q16.16 x Q16.16 -> Q32.32, magnitude at most 2^62
  always_ff @(posedge clk) begin
    prod <= item_value * vec_rd;
  end

  assign sum = {res_rd[spmv_pkg::RES_W-1], res_rd} + {prod[spmv_pkg::RES_W-1], prod};

  always_comb begin
    if (sum[spmv_pkg::RES_W] != sum[spmv_pkg::RES_W-1]) begin
      sum_sat = sum[spmv_pkg::RES_W] ? SAT_MIN : SAT_MAX;
    end else begin
      sum_sat = sum[spmv_pkg::RES_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clear_wr) begin
      clr_cnt <= clr_cnt + AW'(1);
    end
  end

  // one write port shared by the clearing pass, accumulate and read-and-clear
  assign res_we    = cmd.clear_wr | cmd.acc_wr | (cmd.ret & row_ok);
  assign res_waddr = cmd.clear_wr ? clr_cnt : row_addr;
  assign res_wdata = cmd.acc_wr ? sum_sat : '0;

  always_ff @(posedge clk) begin
    if (res_we) begin
      res_mem[res_waddr] <= res_wdata;
    end
    res_rd <= res_mem[row_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (cmd.ret) begin
      results.valid <= 1'b1;
    end else if (results.ready) begin
      results.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ret) begin
      results.result_index <= item_row;
      results.result_value <= row_ok ? res_rd : '0;
    end
  end

  assign sts.kind       = spmv_pkg::kind_t'(item_kind);
  assign sts.row_ok     = row_ok;
  assign sts.col_ok     = col_ok;
  assign sts.out_free   = !results.valid || results.ready;
  assign sts.clear_last = clr_cnt == LAST;

  a_reset_drops_output: assert property (@(posedge clk)
    rst |=> !results.valid)
    else $error("output valid survived reset");

  a_valid_from_ret: assert property (@(posedge clk) disable iff (rst)
    $rose(results.valid) |-> $past(cmd.ret))
    else $error("output valid rose without a read-and-clear");

endmodule

/* hdl/sparse_matrix_vector_multiply_top.sv */
// Channel   Role   Payload                                     Fields
// items     sink   load / accumulate / read-and-clear item     kind, row_index, col_index, value
// results   source one result entry, returned by a read item   result_index, result_value
//
// Steps: one item at a time. A load writes the vector store; an accumulate reads
//   both stores, multiplies, adds and writes back; a read-and-clear returns and
//   clears its entry, ordered by the registered store reads and result write port.
// Reset: rst is synchronous. After it, a clearing pass zeroes the result store,
//   one entry a cycle until all MAX_DIM entries are zero, with items held off.
// Stalls: a read-and-clear waits in its last step, taking no items, while a result
//   is still waiting on results; other items keep being taken while one is pending.
module sparse_matrix_vector_multiply_top #(
  parameter int MAX_DIM = 1024
) (
  input  logic        clk,
  input  logic        rst,
  spmv_in_if.sink     items,
  spmv_out_if.source  results
);

  spmv_pkg::cmd_t    cmd;
  spmv_pkg::status_t sts;

  // Sequencer: clearing pass, item capture, and step order per kind.
  spmv_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (items.valid),
    .in_ready (items.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Item register, vector and result stores, multiplier, saturating adder
  // and the output register.
  spmv_dpath #(
    .MAX_DIM (MAX_DIM)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .kind      (items.kind),
    .row_index (items.row_index),
    .col_index (items.col_index),
    .value     (items.value),
    .cmd       (cmd),
    .sts       (sts),
    .results   (results)
  );

endmodule

/* dv/testbench.sv */
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int KIND_W = spmv_pkg::KIND_W;
  localparam int IDX_W  = spmv_pkg::IDX_W;
  localparam int VAL_W  = spmv_pkg::VAL_W;
  localparam int RES_W  = spmv_pkg::RES_W;

  // Kind code that the block must ignore without producing a result
  localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

  localparam logic signed [RES_W-1:0] SUM_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [RES_W-1:0] SUM_MIN = 64'sh8000_0000_0000_0000;

  localparam int DIM         = 1024;
  localparam int PHASE_ITEMS = 330;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE      = 20;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [IDX_W-1:0]  row;
    logic [IDX_W-1:0]  col;
    logic [VAL_W-1:0]  value;
  } matrix_item_t;

  typedef struct packed {
    logic [IDX_W-1:0] index;
    logic [RES_W-1:0] value;
  } row_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  spmv_in_if  items_if ();
  spmv_out_if results_if ();

  sparse_matrix_vector_multiply_top #(
    .MAX_DIM (DIM)
  ) u_dut (
    .clk     (clk),
    .rst     (rst),
    .items   (items_if),
    .results (results_if)
  );

  // 12 ns period
  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // Items waiting for the driver, and the row sums the block still owes us
  matrix_item_t pending_items[$];
  row_result_t  awaited_rows[$];
  matrix_item_t on_bus;

  // Mirror of the block's stores, advanced on every accepted transfer
  logic [VAL_W-1:0]        vec_model [DIM];
  logic signed [RES_W-1:0] row_sums  [DIM];

  // Columns loaded so far on the stimulus side; accumulates only use these,
  // since an unwritten vector element has no defined value
  bit                vec_loaded [DIM];
  logic [IDX_W-1:0]  loaded_cols[$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int error_count    = 0;

  // Long receiver hold-off, counted down in its own process
  logic hold_go   = 1'b0;
  int   hold_left = 0;

  // Apply one accepted item to the mirror and queue the result it owes.
  function automatic void absorb_item(input matrix_item_t it);
    longint                  prod;
    logic signed [RES_W-1:0] acc;
    logic signed [RES_W-1:0] sum;
    row_result_t             res;
    case (it.kind)
      spmv_pkg::KIND_LOAD: vec_model[it.col] = it.value;
      spmv_pkg::KIND_ACC: begin
        // Q16.16 times Q16.16 is exact in Q32.32; magnitude never above 2^62
        prod = longint'($signed(it.value)) * longint'($signed(vec_model[it.col]));
        acc  = row_sums[it.row];
        sum  = acc + prod;
        // Same-sign operands with a flipped sign bit: clamp to the rail
        if (acc[RES_W-1] == prod[RES_W-1] && sum[RES_W-1] != acc[RES_W-1]) begin
          sum = acc[RES_W-1] ? SUM_MIN : SUM_MAX;
        end
        row_sums[it.row] = sum;
      end
      spmv_pkg::KIND_READ: begin
        res.index = it.row;
        res.value = row_sums[it.row];
        awaited_rows.push_back(res);
        row_sums[it.row] = '0;
      end
      default: ;
    endcase
  endfunction

  function automatic void push_item(input logic [KIND_W-1:0] kind,
                                    input logic [IDX_W-1:0] row,
                                    input logic [IDX_W-1:0] col,
                                    input logic [VAL_W-1:0] value);
    matrix_item_t it;
    it.kind  = kind;
    it.row   = row;
    it.col   = col;
    it.value = value;
    if (kind == spmv_pkg::KIND_LOAD && !vec_loaded[col]) begin
      vec_loaded[col] = 1'b1;
      loaded_cols.push_back(col);
    end
    pending_items.push_back(it);
  endfunction

  // Queue one random item; return 1 if it is one the block acts on.
  function automatic bit queue_random_item();
    int               roll;
    int               vroll;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic [VAL_W-1:0] value;
    roll  = $urandom_range(99);
    vroll = $urandom_range(99);
    // Keep most rows in a small pool so sums build up and saturate
    row   = ($urandom_range(99) < 60) ? IDX_W'($urandom_range(15)) : IDX_W'($urandom);
    if (vroll < 10)      value = 32'h8000_0000;
    else if (vroll < 20) value = 32'h7FFF_FFFF;
    else if (vroll < 25) value = '0;
    else                 value = $urandom;
    if (roll < 20 || loaded_cols.size() == 0) begin
      col = ($urandom_range(1) != 0) ? IDX_W'($urandom_range(31)) : IDX_W'($urandom);
      push_item(spmv_pkg::KIND_LOAD, row, col, value);
      return 1'b1;
    end
    if (roll < 70) begin
      col = loaded_cols[$urandom_range(loaded_cols.size() - 1)];
      push_item(spmv_pkg::KIND_ACC, row, col, value);
      return 1'b1;
    end
    if (roll < 95) begin
      push_item(spmv_pkg::KIND_READ, row, IDX_W'($urandom), value);
      return 1'b1;
    end
    push_item(KIND_SPARE, row, IDX_W'($urandom), value);
    return 1'b0;
  endfunction

  // Block until every queued item is accepted and every result is back.
  task automatic wait_drained();
    while (pending_items.size() > 0 || items_if.valid || awaited_rows.size() > 0) begin
      @(posedge clk);
    end
  endtask

  // Driver: on an accepted transfer advance the mirror, then present the next
  // item or idle. Only touch the bus when the slot is free, so valid is never
  // dropped under a waiting item.
  always @(posedge clk) begin
    if (rst) begin
      items_if.valid <= 1'b0;
    end else begin
      if (items_if.valid && items_if.ready) begin
        absorb_item(on_bus);
      end
      if (!items_if.valid || items_if.ready) begin
        if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          on_bus = pending_items.pop_front();
          items_if.valid     <= 1'b1;
          items_if.kind      <= on_bus.kind;
          items_if.row_index <= on_bus.row;
          items_if.col_index <= on_bus.col;
          items_if.value     <= on_bus.value;
        end else begin
          items_if.valid <= 1'b0;
        end
      end
    end
  end

  // Hold-off counter: a pulse on hold_go stalls the receiver for a long stretch.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_go) begin
      hold_left <= HOLD_CYCLES;
    end
  end

  // Monitor: compare each result transfer with the oldest row sum owed, then
  // pick the next ready at random.
  always @(posedge clk) begin
    if (results_if.valid && results_if.ready) begin
      if (awaited_rows.size() == 0) begin
        $error("unexpected result: result_index %0d, result_value %0d",
               results_if.result_index, $signed(results_if.result_value));
        error_count++;
      end else begin
        if (results_if.result_index !== awaited_rows[0].index) begin
          $error("result_index: expected %0d, actual %0d",
                 awaited_rows[0].index, results_if.result_index);
          error_count++;
        end
        if (results_if.result_value !== awaited_rows[0].value) begin
          $error("result_value: expected %0d, actual %0d",
                 $signed(awaited_rows[0].value), $signed(results_if.result_value));
          error_count++;
        end
        void'(awaited_rows.pop_front());
      end
    end
    if (rst) begin
      results_if.ready <= 1'b0;
    end else begin
      results_if.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Stimulus
  initial begin
    items_if.valid     = 1'b0;
    items_if.kind      = spmv_pkg::KIND_LOAD;
    items_if.row_index = '0;
    items_if.col_index = '0;
    items_if.value     = '0;
    results_if.ready   = 1'b0;
    foreach (row_sums[i]) begin
      row_sums[i]   = '0;
      vec_model[i]  = '0;
      vec_loaded[i] = 1'b0;
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed part: field extremes, both saturation rails, read-and-clear,
    // a row never touched, and the ignored kind.
    push_item(spmv_pkg::KIND_LOAD, 10'd0,    10'd0,    32'h8000_0000);
    push_item(spmv_pkg::KIND_LOAD, 10'd0,    10'd1023, 32'h7FFF_FFFF);
    push_item(spmv_pkg::KIND_LOAD, 10'd1023, 10'd1,    32'h0001_0000);
    push_item(spmv_pkg::KIND_LOAD, 10'd0,    10'd2,    32'hFFFF_FFFF);
    push_item(spmv_pkg::KIND_READ, 10'd5,    10'd1023, 32'h0);
    // min times min twice overflows the positive rail
    push_item(spmv_pkg::KIND_ACC,  10'd0,    10'd0,    32'h8000_0000);
    push_item(spmv_pkg::KIND_ACC,  10'd0,    10'd0,    32'h8000_0000);
    push_item(spmv_pkg::KIND_ACC,  10'd0,    10'd1,    32'h7FFF_FFFF);
    push_item(spmv_pkg::KIND_READ, 10'd0,    10'd0,    32'hFFFF_FFFF);
    // second read of the same row must see the cleared entry
    push_item(spmv_pkg::KIND_READ, 10'd0,    10'd0,    32'h0);
    // min times max three times runs into the negative rail
    push_item(spmv_pkg::KIND_ACC,  10'd1023, 10'd1023, 32'h8000_0000);
    push_item(spmv_pkg::KIND_ACC,  10'd1023, 10'd1023, 32'h8000_0000);
    push_item(spmv_pkg::KIND_ACC,  10'd1023, 10'd1023, 32'h8000_0000);
    push_item(spmv_pkg::KIND_READ, 10'd1023, 10'd0,    32'h0);
    push_item(KIND_SPARE,          10'd1023, 10'd1023, 32'hFFFF_FFFF);
    // smallest step: -1 LSB times -1 LSB
    push_item(spmv_pkg::KIND_ACC,  10'd2,    10'd2,    32'hFFFF_FFFF);
    push_item(spmv_pkg::KIND_ACC,  10'd2,    10'd1,    32'h0);
    push_item(spmv_pkg::KIND_READ, 10'd2,    10'd0,    32'h0);
    push_item(spmv_pkg::KIND_ACC,  10'd3,    10'd1,    32'h0002_0000);
    push_item(spmv_pkg::KIND_ACC,  10'd3,    10'd2,    32'h0000_0001);
    push_item(spmv_pkg::KIND_READ, 10'd3,    10'd0,    32'h0);
    // overwrite a vector element with zero
    push_item(spmv_pkg::KIND_LOAD, 10'd0,    10'd0,    32'h0);
    push_item(spmv_pkg::KIND_ACC,  10'd4,    10'd0,    32'h7FFF_FFFF);
    push_item(spmv_pkg::KIND_READ, 10'd4,    10'd0,    32'h0);
    wait_drained();

    // Random part, one phase per idling pattern
    for (int phase = 0; phase < 4; phase++) begin
      int drawn;
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
        default: begin send_idle_pct = 26; recv_stall_pct = 26; end
      endcase
      drawn = 0;
      while (drawn < PHASE_ITEMS) begin
        if (queue_random_item()) drawn++;
      end
      wait_drained();
    end

    // Back-pressure: hold the receiver off while items keep coming, with
    // reads often enough that a pending result blocks the input.
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    @(posedge clk);
    hold_go <= 1'b1;
    @(posedge clk);
    hold_go <= 1'b0;
    for (int i = 0; i < 48; i++) begin
      if (i % 3 == 2) begin
        push_item(spmv_pkg::KIND_READ, IDX_W'(i % 8), IDX_W'($urandom), $urandom);
      end else begin
        push_item(spmv_pkg::KIND_ACC, IDX_W'(i % 8),
                  loaded_cols[$urandom_range(loaded_cols.size() - 1)], $urandom);
      end
    end
    wait_drained();

    // Let any late or stray result show up before judging
    repeat (SETTLE) @(posedge clk);
    if (error_count == 0 && awaited_rows.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #3_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
